>>> rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared codes and types for the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_POS  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ     = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              rd;
  } req_resp_t;

endpackage

`default_nettype wire

>>> rtl/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of signed 32-bit values in a row of shifting cells, with
// insert, delete and read by 1-based position.
//
// Channel  Dir  Bits  Contents (low bit first)
// s_*      in   40    func[2:0], position[7:3], value_in[39:8]
// m_*      out  40    status[1:0], value_out[33:2], element_count[38:34], 0
//
// One request per cycle: decode, range check and the cell update all finish
// in the accepting cycle; the result lands in the output register.
// Insert and delete shift the cells from the target slot on in parallel, by one slot.
// Reset clears the fill level and the output valid; slot contents are kept.
// A stalled result holds s_tready low until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_top
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // func, position, value_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata    // status, value_out, element_count, pad
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NR = (CAPACITY < 31) ? CAPACITY : 31;

  logic [FUNC_W-1:0]  func;
  logic [POS_W-1:0]   position;
  logic [DATA_W-1:0]  value_in;
  logic               accept;

  logic [CW-1:0]      fill;
  logic [CW-1:0]      fill_next;
  cell_cmd_t          cmd;
  cell_cmd_t          cell_cmd;
  logic [CW-1:0]      idx;
  req_resp_t          resp;

  logic [DATA_W-1:0]  cell_data [CAPACITY];
  logic [POS_W-1:0]   rd_idx;
  logic [DATA_W-1:0]  rd_value;

  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [DATA_W-1:0]  out_value;
  logic [COUNT_W-1:0] out_count;

  assign func     = s_tdata[2:0];
  assign position = s_tdata[7:3];
  assign value_in = s_tdata[39:8];

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  ple_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .func      (func),
    .position  (position),
    .value_in  (value_in),
    .fill      (fill),
    .cmd       (cmd),
    .idx       (idx),
    .resp      (resp),
    .fill_next (fill_next)
  );

  always_comb begin
    cell_cmd = cmd;
    if (!accept) begin
      cell_cmd.op = CELL_HOLD;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_W-1:0] head_side;
      logic [DATA_W-1:0] tail_side;
      if (gi == 0) begin : g_first
        assign head_side = '0;
      end else begin : g_mid
        assign head_side = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign tail_side = '0;
      end else begin : g_body
        assign tail_side = cell_data[gi+1];
      end
      ple_cell #(
        .IDX (gi),
        .KW  (CW)
      ) u_cell (
        .clk       (clk),
        .en        (accept),
        .cmd       (cell_cmd),
        .idx       (idx),
        .head_side (head_side),
        .tail_side (tail_side),
        .data      (cell_data[gi])
      );
    end
  endgenerate

  // only the first 31 slots are reachable through a 5-bit position
  assign rd_idx = position - POS_W'(1);

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < NR; i++) begin
      if (rd_idx == POS_W'(i)) begin
        rd_value = cell_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= resp.status;
      out_value  <= resp.rd ? rd_value : '0;
      out_count  <= COUNT_W'(fill_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_count, out_value, out_status};

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill level above capacity");

  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(fill))
    else $error("fill level moved without a transfer");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (fill == $past(fill) || fill == $past(fill) + CW'(1) ||
                fill == $past(fill) - CW'(1)))
    else $error("fill level moved by more than one");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_FULL) |-> (out_count == COUNT_W'(CAPACITY)))
    else $error("full status with a count below capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_value == '0))
    else $error("error result carries a value");

endmodule

`default_nettype wire

>>> rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds, takes its tail-side neighbor, its head-side neighbor,
// or the new value, depending on the command and its own position.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned KW    = 5
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire cell_cmd_t         cmd,
  input  wire logic [KW-1:0]     idx,
  input  wire logic [DATA_W-1:0] head_side,
  input  wire logic [DATA_W-1:0] tail_side,
  output logic      [DATA_W-1:0] data
);

  localparam logic [KW-1:0] MY_IDX = KW'(IDX);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.op)
      CELL_INSERT: begin
        if (MY_IDX > idx) begin
          data_next = head_side;
        end else if (MY_IDX == idx) begin
          data_next = cmd.value;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= idx) begin
          data_next = tail_side;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Request decode: range checks against the fill level, cell command and
// slot index, status and next fill level.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CW       = 5
) (
  input  wire logic [FUNC_W-1:0] func,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [DATA_W-1:0] value_in,
  input  wire logic [CW-1:0]     fill,
  output cell_cmd_t              cmd,
  output logic      [CW-1:0]     idx,
  output req_resp_t              resp,
  output logic      [CW-1:0]     fill_next
);

  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] fill_w;
  logic          full;

  assign pos_w  = PW'(position);
  assign fill_w = PW'(fill);
  assign full   = (fill_w >= PW'(CAPACITY));

  always_comb begin
    cmd.op      = CELL_HOLD;
    cmd.value   = value_in;
    idx         = '0;
    resp.status = ST_OK;
    resp.rd     = 1'b0;
    fill_next   = fill;
    case (func)
      FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
        if (full) begin
          resp.status = ST_FULL;
        end else if (func == FN_INS_HEAD || (func == FN_INS_POS && pos_w <= PW'(1))) begin
          cmd.op    = CELL_INSERT;
          fill_next = fill + CW'(1);
        end else if (func == FN_INS_TAIL) begin
          cmd.op    = CELL_INSERT;
          idx       = fill;
          fill_next = fill + CW'(1);
        end else if (pos_w <= fill_w + PW'(1)) begin
          cmd.op    = CELL_INSERT;
          idx       = CW'(pos_w - PW'(1));
          fill_next = fill + CW'(1);
        end else begin
          resp.status = ST_BAD;
        end
      end
      FN_DELETE, FN_READ: begin
        if (pos_w == '0 || pos_w > fill_w) begin
          resp.status = ST_BAD;
        end else begin
          resp.rd = 1'b1;
          if (func == FN_DELETE) begin
            cmd.op    = CELL_DELETE;
            idx       = CW'(pos_w - PW'(1));
            fill_next = fill - CW'(1);
          end
        end
      end
      default: begin
        resp.status = ST_BAD;
      end
    endcase
  end

endmodule

`default_nettype wire
